/* rtl/ultrasonic_echo_range_display_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the echo range display
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGE_DISPLAY_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGE_DISPLAY_DEFINES_SVH

// same-cycle implication
`define UERD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UERD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/uerd_pkg.sv */
// ----------------------------------------------------------------------------
// Echo range display package
// Widths, reset values, register indexes and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uerd_pkg;

    localparam int ECHO_W  = 17;   // echo tick counter width
    localparam int TRIG_W  = 10;
    localparam int PER_W   = 24;
    localparam int LIMIT_W = 17;
    localparam int TPT_W   = 16;
    localparam int DIST_W  = 14;
    localparam int DIGIT_W = 4;
    localparam int NDIGITS = 4;
    localparam int BCD_W   = DIGIT_W * NDIGITS;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PER_W;
    localparam int MAX_STEPS  = (ECHO_W > DIST_W) ? ECHO_W : DIST_W;
    localparam int STEP_W     = $clog2(MAX_STEPS);

    localparam logic [TRIG_W-1:0]  TRIG_RST   = TRIG_W'(500);
    localparam logic [PER_W-1:0]   PERIOD_RST = PER_W'(5000000);
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(93749);
    localparam logic [TPT_W-1:0]   TPT_RST    = TPT_W'(290);
    localparam logic [DIST_W-1:0]  MAX_TENTHS = DIST_W'(9999);
    localparam logic [DIGIT_W-1:0] BLANK_DIGIT = DIGIT_W'(15);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_TICKS   = 2'd0,
        CFG_PERIOD_TICKS    = 2'd1,
        CFG_ECHO_LIMIT      = 2'd2,
        CFG_TICKS_PER_TENTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic take;        // input word accepted, run the tick update
        logic div_step;
        logic bcd_start;   // saturate quotient, start digit conversion
        logic bcd_step;
        logic load_plain;  // output word from held distance
        logic load_fresh;  // output word from new distance, commit it
    } t_cmd;

    typedef struct packed {
        logic fall;        // falling echo edge on the offered input word
    } t_sts;

    typedef struct packed {
        logic               trigger_out;
        logic               new_reading;
        logic [DIST_W-1:0]  distance_tenths;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_ones;
        logic [DIGIT_W-1:0] digit_frac;
    } t_out_word;

endpackage

/* rtl/uerd_if.sv */
// ----------------------------------------------------------------------------
// Echo range display channels
// Valid/ready channels for the echo sample and the readout word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface uerd_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface uerd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           trigger_out;
    logic                           new_reading;
    logic [uerd_pkg::DIST_W-1:0]    distance_tenths;
    logic [uerd_pkg::DIGIT_W-1:0]   digit_hundreds;
    logic [uerd_pkg::DIGIT_W-1:0]   digit_tens;
    logic [uerd_pkg::DIGIT_W-1:0]   digit_ones;
    logic [uerd_pkg::DIGIT_W-1:0]   digit_frac;

    modport source (output valid, output trigger_out, output new_reading,
                    output distance_tenths, output digit_hundreds, output digit_tens,
                    output digit_ones, output digit_frac, input ready);
    modport sink   (input valid, input trigger_out, input new_reading,
                    input distance_tenths, input digit_hundreds, input digit_tens,
                    input digit_ones, input digit_frac, output ready);
endinterface

/* rtl/ultrasonic_echo_range_display.sv */
// ----------------------------------------------------------------------------
// Ultrasonic echo range display
// Trigger generator, echo pulse timer and four-digit distance readout.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  i_in      in   valid/ready    echo_level (one clock tick)
//  o_out     out  valid/ready    trigger, new_reading, distance, four digits
//  i_cfg_*   in   write enable   register index, data
//
//  A word without a falling echo edge is loaded to the output as it is taken.
//  A falling edge runs the restoring divider, one quotient bit per cycle, a
//  saturate step, then the double-dabble converter one binary bit per cycle.
//  A new word is taken in the same cycle the last result leaves the output.
//  Synchronous active-low reset; a stalled output holds the input off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_echo_range_display (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    uerd_in_if.sink                         i_in,
    uerd_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [uerd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [uerd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import uerd_pkg::*;

    t_cmd      cmd;
    t_sts      sts;
    t_out_word word;

    uerd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    uerd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_echo_level (i_in.echo_level),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_word       (word)
    );

    assign o_out.trigger_out     = word.trigger_out;
    assign o_out.new_reading     = word.new_reading;
    assign o_out.distance_tenths = word.distance_tenths;
    assign o_out.digit_hundreds  = word.digit_hundreds;
    assign o_out.digit_tens      = word.digit_tens;
    assign o_out.digit_ones      = word.digit_ones;
    assign o_out.digit_frac      = word.digit_frac;

endmodule

/* rtl/uerd_ctrl.sv */
// ----------------------------------------------------------------------------
// Echo range display controller
// Sequences tick update, division, digit conversion and output load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uerd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  uerd_pkg::t_sts  i_sts,
    output uerd_pkg::t_cmd  o_cmd
);
    import uerd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SAT  = 5'b00100,
        S_BCD  = 5'b01000,
        S_LOAD = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              slot_free;
    logic              take;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && slot_free;
    assign take        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = take;
                if (take && i_sts.fall) begin
                    n_state = S_DIV;
                    n_cnt   = STEP_W'(ECHO_W - 1);
                end else if (take) begin
                    o_cmd.load_plain = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - STEP_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.bcd_start = 1'b1;
                n_state = S_BCD;
                n_cnt   = STEP_W'(DIST_W - 1);
            end
            S_BCD: begin
                o_cmd.bcd_step = 1'b1;
                n_cnt = r_cnt - STEP_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (slot_free) begin
                    o_cmd.load_fresh = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_plain || o_cmd.load_fresh) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/uerd_dp.sv */
// ----------------------------------------------------------------------------
// Echo range display datapath
// Config registers, trigger and echo counters, divider, BCD converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uerd_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uerd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [uerd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_echo_level,
    input  uerd_pkg::t_cmd                  i_cmd,
    output uerd_pkg::t_sts                  o_sts,
    output uerd_pkg::t_out_word             o_word
);
    import uerd_pkg::*;

    localparam int CMP_W  = (ECHO_W > LIMIT_W) ? ECHO_W : LIMIT_W;
    localparam int QCMP_W = (ECHO_W > DIST_W) ? ECHO_W : DIST_W;

    // configuration
    logic [TRIG_W-1:0]  r_cfg_trig;
    logic [PER_W-1:0]   r_cfg_period;
    logic [LIMIT_W-1:0] r_cfg_limit;
    logic [TPT_W-1:0]   r_cfg_tpt;

    // tick state
    logic               r_echo_last;
    logic [ECHO_W-1:0]  r_echo_ticks, n_echo_ticks;
    logic [PER_W-1:0]   r_period_cnt, n_period_cnt;
    logic [TRIG_W-1:0]  r_trig_cnt, n_trig_cnt;
    logic [DIST_W-1:0]  r_held;
    logic [BCD_W-1:0]   r_bcd;

    // work registers
    logic               r_trig_pend;
    logic [TPT_W-1:0]   r_rem, n_rem;
    logic [ECHO_W-1:0]  r_quo, n_quo;
    logic [DIST_W-1:0]  r_bin;
    logic [DIST_W-1:0]  r_dist_new;
    logic [BCD_W-1:0]   r_bcd_work, n_bcd_work;
    t_out_word          r_word;

    logic [PER_W-1:0]   period_eff;
    logic [PER_W:0]     cnt_inc;
    logic               wrap;
    logic [TRIG_W-1:0]  trig_ld;
    logic               trig_now;
    logic               rise;
    logic               fall;
    logic               can_inc;
    logic [TPT_W:0]     shifted;
    logic [TPT_W:0]     diff;
    logic               ge;
    logic [QCMP_W-1:0]  quo_x;
    logic [DIST_W-1:0]  quo_sat;
    logic [BCD_W-1:0]   bcd_adj;

    function automatic t_out_word make_word(input logic trig, input logic fresh,
                                            input logic [DIST_W-1:0] dist_val,
                                            input logic [BCD_W-1:0] bcd);
        t_out_word w;
        w.trigger_out     = trig;
        w.new_reading     = fresh;
        w.distance_tenths = dist_val;
        // leading positions blank below 100.0 cm and 10.0 cm
        w.digit_hundreds  = (bcd[15:12] != '0) ? bcd[15:12] : BLANK_DIGIT;
        w.digit_tens      = (bcd[15:8] != '0) ? bcd[11:8] : BLANK_DIGIT;
        w.digit_ones      = bcd[7:4];
        w.digit_frac      = bcd[3:0];
        return w;
    endfunction

    // period and trigger
    assign period_eff = (r_cfg_period == '0) ? PER_W'(1) : r_cfg_period;
    assign cnt_inc    = {1'b0, r_period_cnt} + (PER_W + 1)'(1);
    assign wrap       = cnt_inc >= {1'b0, period_eff};
    assign trig_ld    = wrap ? r_cfg_trig : r_trig_cnt;
    assign trig_now   = trig_ld != '0;
    assign n_trig_cnt   = trig_now ? trig_ld - TRIG_W'(1) : trig_ld;
    assign n_period_cnt = wrap ? '0 : cnt_inc[PER_W-1:0];

    // echo edges
    assign rise     = i_echo_level && !r_echo_last;
    assign fall     = !i_echo_level && r_echo_last;
    assign o_sts.fall = fall;
    assign can_inc  = (CMP_W'(r_echo_ticks) < CMP_W'(r_cfg_limit)) && (r_echo_ticks != '1);

    always_comb begin
        n_echo_ticks = r_echo_ticks;
        if (rise) begin
            n_echo_ticks = '0;
        end else if (i_echo_level && can_inc) begin
            n_echo_ticks = r_echo_ticks + ECHO_W'(1);
        end
    end

    // restoring divider, one quotient bit per step; zero divisor gives all ones
    assign shifted = {r_rem, r_quo[ECHO_W-1]};
    assign diff    = shifted - {1'b0, r_cfg_tpt};
    assign ge      = shifted >= {1'b0, r_cfg_tpt};
    assign n_rem   = ge ? diff[TPT_W-1:0] : shifted[TPT_W-1:0];
    assign n_quo   = {r_quo[ECHO_W-2:0], ge};

    assign quo_x   = QCMP_W'(r_quo);
    assign quo_sat = (quo_x > QCMP_W'(MAX_TENTHS)) ? MAX_TENTHS : quo_x[DIST_W-1:0];

    // double dabble step
    always_comb begin
        for (int i = 0; i < NDIGITS; i++) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] =
                (r_bcd_work[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
                r_bcd_work[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) :
                r_bcd_work[i*DIGIT_W +: DIGIT_W];
        end
    end
    assign n_bcd_work = {bcd_adj[BCD_W-2:0], r_bin[DIST_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_trig   <= TRIG_RST;
            r_cfg_period <= PERIOD_RST;
            r_cfg_limit  <= LIMIT_RST;
            r_cfg_tpt    <= TPT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRIGGER_TICKS:   r_cfg_trig   <= i_cfg_data[TRIG_W-1:0];
                CFG_PERIOD_TICKS:    r_cfg_period <= i_cfg_data[PER_W-1:0];
                CFG_ECHO_LIMIT:      r_cfg_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_TICKS_PER_TENTH: r_cfg_tpt    <= i_cfg_data[TPT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_last  <= 1'b0;
            r_echo_ticks <= '0;
            r_period_cnt <= '0;
            r_trig_cnt   <= '0;
            r_held       <= '0;
            r_bcd        <= '0;
        end else begin
            if (i_cmd.take) begin
                r_echo_last  <= i_echo_level;
                r_echo_ticks <= n_echo_ticks;
                r_period_cnt <= n_period_cnt;
                r_trig_cnt   <= n_trig_cnt;
            end
            if (i_cmd.load_fresh) begin
                r_held <= r_dist_new;
                r_bcd  <= r_bcd_work;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_trig_pend <= trig_now;
            r_rem       <= '0;
            r_quo       <= r_echo_ticks;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.bcd_start) begin
            r_bin      <= quo_sat;
            r_dist_new <= quo_sat;
            r_bcd_work <= '0;
        end
        if (i_cmd.bcd_step) begin
            r_bin      <= {r_bin[DIST_W-2:0], 1'b0};
            r_bcd_work <= n_bcd_work;
        end
        if (i_cmd.load_plain) begin
            r_word <= make_word(trig_now, 1'b0, r_held, r_bcd);
        end else if (i_cmd.load_fresh) begin
            r_word <= make_word(r_trig_pend, 1'b1, r_dist_new, r_bcd_work);
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/uerd_checker.sv */
// ----------------------------------------------------------------------------
// Echo range display checker
// Port-level properties of the readout channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_echo_range_display_defines.svh"

module uerd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [uerd_pkg::DIST_W-1:0]   i_distance_tenths,
    input  logic [uerd_pkg::DIGIT_W-1:0]  i_digit_hundreds,
    input  logic [uerd_pkg::DIGIT_W-1:0]  i_digit_tens,
    input  logic [uerd_pkg::DIGIT_W-1:0]  i_digit_ones,
    input  logic [uerd_pkg::DIGIT_W-1:0]  i_digit_frac
);
    import uerd_pkg::*;

    // a shown hundreds digit implies the tens digit is shown too
    `UERD_ASSERT_IMP(a_blank_order, i_clk, i_rst_n, i_out_valid && (i_digit_hundreds != BLANK_DIGIT), i_digit_tens != BLANK_DIGIT, "tens blank under shown hundreds")
    `UERD_ASSERT_IMP(a_dist_sat, i_clk, i_rst_n, i_out_valid, i_distance_tenths <= MAX_TENTHS, "distance above 9999")
    `UERD_ASSERT_IMP(a_low_digits, i_clk, i_rst_n, i_out_valid, (i_digit_ones <= DIGIT_W'(9)) && (i_digit_frac <= DIGIT_W'(9)), "low digit out of range")
    `UERD_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_distance_tenths), "stalled word changed")

endmodule

bind ultrasonic_echo_range_display uerd_checker u_uerd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_distance_tenths (o_out.distance_tenths),
    .i_digit_hundreds  (o_out.digit_hundreds),
    .i_digit_tens      (o_out.digit_tens),
    .i_digit_ones      (o_out.digit_ones),
    .i_digit_frac      (o_out.digit_frac)
);

/* tb/tb_ultrasonic_echo_range_display.sv */
// ----------------------------------------------------------------------------
// Echo range display testbench
// Streams echo samples through the block with random gaps on both channels,
// predicts trigger, fresh flag, held distance and digits for every sample,
// and compares each readout word in order. Settings change between phases
// with the block drained, from the extremes to random picks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ultrasonic_echo_range_display;
    import uerd_pkg::*;

    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 50;    // settle margin beyond the divide + convert

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    uerd_in_if  echo_ch ();
    uerd_out_if readout_ch ();

    ultrasonic_echo_range_display dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (echo_ch),
        .o_out      (readout_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor settings and state
    logic [TRIG_W-1:0]  cfg_trigger_ticks = TRIG_RST;
    logic [PER_W-1:0]   cfg_period        = PERIOD_RST;
    logic [LIMIT_W-1:0] cfg_echo_limit    = LIMIT_RST;
    logic [TPT_W-1:0]   cfg_tpt           = TPT_RST;

    logic               echo_prev    = 1'b0;
    logic [ECHO_W-1:0]  echo_count   = '0;
    logic [PER_W-1:0]   period_pos   = '0;
    logic [TRIG_W-1:0]  trig_left    = '0;
    logic [DIST_W-1:0]  held_tenths  = '0;

    bit        pending_echo[$];
    t_out_word expected_readouts[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned holdoff_left  = 0;
    logic        holdoff_kick  = 1'b0;

    int unsigned words_sent       = 0;
    int unsigned readouts_checked = 0;
    int unsigned fresh_readings   = 0;
    int unsigned settings_applied = 0;
    int unsigned mismatch_count   = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // one tick of the rangefinder: trigger, echo timer, held distance, digits
    function automatic t_out_word step_rangefinder(logic echo);
        t_out_word   w;
        int unsigned per;
        int unsigned quotient;
        int unsigned d;
        per = (cfg_period == '0) ? 1 : 32'(cfg_period);
        if (32'(period_pos) + 1 >= per) begin
            period_pos = '0;
            trig_left  = cfg_trigger_ticks;
        end else begin
            period_pos = period_pos + PER_W'(1);
        end
        w.trigger_out = (trig_left != '0);
        if (trig_left != '0)
            trig_left = trig_left - TRIG_W'(1);

        w.new_reading = 1'b0;
        if (echo && !echo_prev) begin
            echo_count = '0;
        end else if (echo) begin
            if (32'(echo_count) < 32'(cfg_echo_limit) && echo_count != '1)
                echo_count = echo_count + ECHO_W'(1);
        end else if (echo_prev) begin
            if (cfg_tpt == '0)
                quotient = 32'(MAX_TENTHS);
            else
                quotient = 32'(echo_count) / 32'(cfg_tpt);
            held_tenths   = (quotient > 32'(MAX_TENTHS)) ? MAX_TENTHS : DIST_W'(quotient);
            w.new_reading = 1'b1;
        end
        echo_prev = echo;

        d = 32'(held_tenths);
        w.distance_tenths = held_tenths;
        w.digit_hundreds  = (d >= 1000) ? DIGIT_W'((d / 1000) % 10) : BLANK_DIGIT;
        w.digit_tens      = (d >= 100) ? DIGIT_W'((d / 100) % 10) : BLANK_DIGIT;
        w.digit_ones      = DIGIT_W'((d / 10) % 10);
        w.digit_frac      = DIGIT_W'(d % 10);
        return w;
    endfunction

    // sample driver: predicts each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            echo_ch.valid      <= 1'b0;
            echo_ch.echo_level <= 1'b0;
        end else begin
            if (echo_ch.valid && echo_ch.ready) begin
                expected_readouts.push_back(step_rangefinder(echo_ch.echo_level));
                words_sent++;
            end
            if (!echo_ch.valid || echo_ch.ready) begin
                if (pending_echo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    echo_ch.valid      <= 1'b1;
                    echo_ch.echo_level <= pending_echo.pop_front();
                end else begin
                    echo_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            holdoff_left <= 0;
        else if (holdoff_kick)
            holdoff_left <= HOLDOFF_CYCLES;
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // readout monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            readout_ch.ready <= 1'b0;
        end else begin
            if (readout_ch.valid && readout_ch.ready) begin
                if (expected_readouts.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: readout with none expected, distance %0d", $time,
                             readout_ch.distance_tenths);
                end else begin
                    want = expected_readouts.pop_front();
                    readouts_checked++;
                    if (want.new_reading)
                        fresh_readings++;
                    check_field("trigger_out", 32'(want.trigger_out),
                                32'(readout_ch.trigger_out));
                    check_field("new_reading", 32'(want.new_reading),
                                32'(readout_ch.new_reading));
                    check_field("distance_tenths", 32'(want.distance_tenths),
                                32'(readout_ch.distance_tenths));
                    check_field("digit_hundreds", 32'(want.digit_hundreds),
                                32'(readout_ch.digit_hundreds));
                    check_field("digit_tens", 32'(want.digit_tens),
                                32'(readout_ch.digit_tens));
                    check_field("digit_ones", 32'(want.digit_ones),
                                32'(readout_ch.digit_ones));
                    check_field("digit_frac", 32'(want.digit_frac),
                                32'(readout_ch.digit_frac));
                end
            end
            readout_ch.ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (pending_echo.size() != 0 || echo_ch.valid || expected_readouts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_TRIGGER_TICKS:   cfg_trigger_ticks = value[TRIG_W-1:0];
            CFG_PERIOD_TICKS:    cfg_period        = value[PER_W-1:0];
            CFG_ECHO_LIMIT:      cfg_echo_limit    = value[LIMIT_W-1:0];
            CFG_TICKS_PER_TENTH: cfg_tpt           = value[TPT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned trig, int unsigned period,
                              int unsigned limit, int unsigned tpt);
        write_reg(CFG_TRIGGER_TICKS, CFG_DATA_W'(trig));
        write_reg(CFG_PERIOD_TICKS, CFG_DATA_W'(period));
        write_reg(CFG_ECHO_LIMIT, CFG_DATA_W'(limit));
        write_reg(CFG_TICKS_PER_TENTH, CFG_DATA_W'(tpt));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic queue_pulse(int unsigned low_len, int unsigned high_len);
        repeat (low_len) pending_echo.push_back(1'b0);
        repeat (high_len) pending_echo.push_back(1'b1);
    endtask

    // mostly clean pulses, short ones favored, with bursts of noise
    task automatic queue_random_echo(int unsigned n_words, int unsigned max_high);
        int unsigned produced;
        int unsigned pick;
        int unsigned low_len;
        int unsigned high_len;
        produced = 0;
        while (produced < n_words) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                low_len = $urandom_range(8, 1);
                repeat (low_len) pending_echo.push_back(1'($urandom_range(1)));
                produced += low_len;
            end else begin
                low_len = $urandom_range(6, 1);
                if (pick < 75)
                    high_len = $urandom_range((max_high < 12) ? max_high : 12, 1);
                else
                    high_len = $urandom_range(max_high, 1);
                queue_pulse(low_len, high_len);
                produced += low_len + high_len;
            end
        end
    endtask

    initial begin
        bit [19:0] opening_pattern;
        opening_pattern    = 20'b0101_1011_1111_0101_1000;
        echo_ch.valid      = 1'b0;
        echo_ch.echo_level = 1'b0;
        readout_ch.ready   = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_TRIGGER_TICKS;
        i_cfg_data         = '0;
        i_rst_n            = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 83;
        // reset settings
        queue_random_echo(60, 20);
        wait_drained();

        // immediate fall, short counts, saturation at a small limit
        set_config(3, 7, 3, 2);
        for (int k = 19; k >= 0; k--)
            pending_echo.push_back(opening_pattern[k]);
        wait_drained();

        // zero trigger, zero period, zero limit, zero divisor (shows 999.9)
        set_config(0, 0, 0, 0);
        queue_random_echo(100, 20);
        wait_drained();

        // pulse longer than period: constant retrigger
        set_config(1023, 5, 131071, 1);
        queue_random_echo(150, 120);
        wait_drained();

        send_idle_pct = 83;
        recv_idle_pct = 26;
        set_config(5, 16777215, 1, 65535);
        queue_random_echo(100, 20);
        wait_drained();

        set_config(1, 1, 37, 3);
        queue_random_echo(150, 60);
        wait_drained();

        set_config(4, 9, 500, 1);
        queue_random_echo(150, 120);
        wait_drained();

        // sink stalls long while samples keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config($urandom_range(15), $urandom_range(40, 1),
                   $urandom_range(300, 1), $urandom_range(8, 1));
        queue_random_echo(200, 40);
        @(posedge i_clk);
        holdoff_kick <= 1'b1;
        @(posedge i_clk);
        holdoff_kick <= 1'b0;
        wait_drained();

        // long echoes: tens blanking around 10.0 cm
        set_config(10, 1000, 131071, 1);
        queue_pulse(3, 100);
        queue_pulse(3, 101);
        queue_pulse(3, 102);
        queue_pulse(3, 0);
        wait_drained();

        set_config($urandom_range(15), $urandom_range(40, 1),
                   $urandom_range(300, 1), $urandom_range(8, 1));
        queue_random_echo(60, 50);
        wait_drained();
        queue_random_echo(60, 50);
        wait_drained();

        $display("Covered %0d echo samples under %0d register settings", words_sent,
                 settings_applied);
        $display("Compared %0d readout words, %0d carrying a fresh distance",
                 readouts_checked, fresh_readings);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Timed out with %0d readouts outstanding", expected_readouts.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/uerd_pkg.sv
rtl/uerd_if.sv
rtl/uerd_ctrl.sv
rtl/uerd_dp.sv
rtl/ultrasonic_echo_range_display.sv
rtl/uerd_checker.sv
tb/tb_ultrasonic_echo_range_display.sv
